// File: hdl/lsb_stego_embed_extract_defines.svh
// assertion macros shared by the lsb stego embed/extract rtl
`ifndef LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH
`define LSB_STEGO_EMBED_EXTRACT_DEFINES_SVH

// base check, clocked on clk and off during reset
`define LSBSE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define LSBSE_ASSERT_IMPL(name, ante, cons, msg) \
  `LSBSE_ASSERT(name, (ante) |-> (cons), msg)

// next-cycle implication
`define LSBSE_ASSERT_NEXT(name, ante, cons, msg) \
  `LSBSE_ASSERT(name, (ante) |=> (cons), msg)

`endif

// File: hdl/lsbse_pkg.sv
// types and constants for the lsb stego embed/extract block
package lsbse_pkg;

  localparam int unsigned POS_W = 12;
  localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;
  localparam logic [POS_W-1:0] HDR_BITS = 12'd8;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_PAYLOAD_LEN = 2'd1;
  localparam logic [1:0] CFG_IMAGE_PIXELS = 2'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_IMAGE = 1'b1
  } opcode_t;

  typedef enum logic {
    MODE_EMBED   = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_t;

  // one result item
  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] data;
    logic       data_valid;
    logic [7:0] xlen;
    logic       done;
    logic       status;
  } result_t;

  // payload buffer write
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } wr_req_t;

  // payload bit fetch for embedding
  typedef struct packed {
    logic       use_bit;
    logic [8:0] byte_idx;
    logic [2:0] bit_sel;
  } rd_req_t;

endpackage

// File: hdl/lsbse_payload_buf.sv
// payload byte buffer with registered read and payload bit select
module lsbse_payload_buf #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  logic              clk,
  input  lsbse_pkg::wr_req_t wr,
  input  logic              rd_adv,
  input  lsbse_pkg::rd_req_t rd,
  output logic              rd_hit,
  output logic              rd_bit
);

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

  logic [7:0]    mem [PAYLOAD_DEPTH];
  logic [7:0]    rd_q_r;
  logic [2:0]    sel_r;
  logic          in_range_r;
  logic          use_r;

  always_ff @(posedge clk) begin
    if (wr.en && (9'(wr.addr) < 9'(PAYLOAD_DEPTH))) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      rd_q_r     <= mem[rd.byte_idx[AW-1:0]];
      sel_r      <= rd.bit_sel;
      in_range_r <= rd.byte_idx < 9'(PAYLOAD_DEPTH);
      use_r      <= rd.use_bit;
    end
  end

  // bytes beyond the buffer read as zero
  assign rd_hit = use_r;
  assign rd_bit = in_range_r & rd_q_r[sel_r];

endmodule

// File: hdl/lsb_stego_embed_extract.sv
// top level of the lsb stego embed/extract stream block
// result path: decode stage, then output register, to out_tvalid
// one item per cycle unless stalled; loads only write the payload buffer, embed items only read it
// in_tready drops only while the decode stage is full and a stalled result sits in the output register
// reset (rst_n, synchronous): clears config registers, position/header/assembly state, valid flags
// the payload buffer is not cleared by reset; entries read as garbage until loaded
`include "lsb_stego_embed_extract_defines.svh"

module lsb_stego_embed_extract #(
  parameter int unsigned PAYLOAD_DEPTH = 256,
  parameter int unsigned CHANNELS      = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // payload_index[7:0], payload_byte[15:8], image_byte[23:16]
  input  logic [1:0]  in_tuser,   // opcode[0], first_byte[1]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_out[7:0], data_out[15:8], extracted_length[23:16]
  output logic [2:0]  out_tuser   // data_valid[0], done_res[1], status[2]
);

  localparam int unsigned POS_W = lsbse_pkg::POS_W;

  // config registers
  lsbse_pkg::mode_t mode_r;
  logic [7:0]       plen_r;
  logic [23:0]      pixels_r;

  // stream state
  logic [POS_W-1:0] bitpos_r, bitpos_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic [7:0]       asm_r, asm_nxt;

  // decode stage and output register
  logic               mid_v_r;
  lsbse_pkg::result_t mid_res_r;
  logic               out_v_r;
  lsbse_pkg::result_t out_res_r;

  // stage a signals
  logic               in_acc;
  logic               is_img;
  logic               first;
  logic               img_bit;
  logic [7:0]         img;
  logic [POS_W-1:0]   p;
  logic [POS_W:0]     p_inc;
  logic [POS_W-1:0]   k;
  logic [POS_W-1:0]   pay_end;
  logic [POS_W-1:0]   ex_end;
  logic [7:0]         hdr0;
  logic [7:0]         asm0;
  logic [7:0]         asm_v;
  logic [26:0]        chan_bytes;
  logic [23:0]        cap;
  logic               refused;
  lsbse_pkg::result_t res_nxt;
  lsbse_pkg::wr_req_t wr;
  lsbse_pkg::rd_req_t rd;

  logic               mid_adv;
  logic               rd_hit;
  logic               rd_bit;
  lsbse_pkg::result_t mid_out;

  // config port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lsbse_pkg::MODE_EMBED;
      plen_r   <= '0;
      pixels_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsbse_pkg::CFG_MODE:         mode_r   <= lsbse_pkg::mode_t'(cfg_data[0]);
        lsbse_pkg::CFG_PAYLOAD_LEN:  plen_r   <= cfg_data[7:0];
        lsbse_pkg::CFG_IMAGE_PIXELS: pixels_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // capacity in bytes is channel bytes / 8 minus one (the header byte)
  // refuse when plen exceeds that, i.e. plen >= channel bytes / 8 with plen nonzero
  assign chan_bytes = 27'(pixels_r) * 27'(CHANNELS);
  assign cap        = chan_bytes[26:3];
  assign refused    = (plen_r != 8'd0) && ({16'd0, plen_r} >= cap);

  // handshake: decode stage moves when output register is free or draining
  assign mid_adv   = !out_v_r || out_tready;
  assign in_tready = !mid_v_r || mid_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign is_img  = (lsbse_pkg::opcode_t'(in_tuser[0]) == lsbse_pkg::OP_IMAGE);
  assign first   = in_tuser[1];
  assign img     = in_tdata[23:16];
  assign img_bit = img[0];

  // first_byte restarts counting before this item is handled
  assign p       = first ? '0 : bitpos_r;
  assign hdr0    = first ? 8'd0 : hdr_r;
  assign asm0    = first ? 8'd0 : asm_r;
  assign p_inc   = {1'b0, p} + 13'd1;
  assign k       = p - lsbse_pkg::HDR_BITS;
  assign pay_end = {1'b0, plen_r, 3'b000} + lsbse_pkg::HDR_BITS;

  always_comb begin
    res_nxt    = '0;
    rd         = '0;
    wr.en      = in_acc && !is_img;
    wr.addr    = in_tdata[7:0];
    wr.data    = in_tdata[15:8];
    bitpos_nxt = bitpos_r;
    hdr_nxt    = hdr_r;
    asm_nxt    = asm_r;
    asm_v      = asm0;
    ex_end     = '0;
    if (is_img) begin
      // position counter saturates instead of wrapping
      bitpos_nxt    = (p == lsbse_pkg::POS_MAX) ? p : p_inc[POS_W-1:0];
      hdr_nxt       = hdr0;
      asm_nxt       = asm0;
      res_nxt.pixel = img;
      if (mode_r == lsbse_pkg::MODE_EMBED) begin
        if (refused) begin
          res_nxt.status = 1'b1;
        end else begin
          if (p < lsbse_pkg::HDR_BITS) begin
            // header: length lsb first
            res_nxt.pixel[0] = plen_r[p[2:0]];
          end else if (p < pay_end) begin
            // payload bit comes out of the buffer in the next stage, msb first
            rd.use_bit  = 1'b1;
            rd.byte_idx = k[11:3];
            rd.bit_sel  = ~k[2:0];
          end
          res_nxt.done = (p_inc >= {1'b0, pay_end});
        end
      end else begin
        if (p < lsbse_pkg::HDR_BITS) begin
          hdr_nxt = hdr0 | (8'(img_bit) << p[2:0]);
        end else if (p < ({1'b0, hdr0, 3'b000} + lsbse_pkg::HDR_BITS)) begin
          asm_v = asm0 | (8'(img_bit) << (~k[2:0]));
          if (k[2:0] == 3'b111) begin
            // byte complete
            res_nxt.data       = asm_v;
            res_nxt.data_valid = 1'b1;
            asm_nxt            = 8'd0;
          end else begin
            asm_nxt = asm_v;
          end
        end
        ex_end       = {1'b0, hdr_nxt, 3'b000} + lsbse_pkg::HDR_BITS;
        res_nxt.xlen = hdr_nxt;
        // done waits for the header to be complete
        res_nxt.done = (p >= 12'd7) && (p_inc >= {1'b0, ex_end});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitpos_r <= '0;
      hdr_r    <= '0;
      asm_r    <= '0;
    end else if (in_acc && is_img) begin
      bitpos_r <= bitpos_nxt;
      hdr_r    <= hdr_nxt;
      asm_r    <= asm_nxt;
    end
  end

  lsbse_payload_buf #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_buf (
    .clk   (clk),
    .wr    (wr),
    .rd_adv(in_acc),
    .rd    (rd),
    .rd_hit(rd_hit),
    .rd_bit(rd_bit)
  );

  // decode stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
    end else if (in_acc) begin
      mid_v_r <= 1'b1;
    end else if (mid_adv) begin
      mid_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_res_r <= res_nxt;
    end
  end

  // merge the fetched payload bit into the pixel lsb
  always_comb begin
    mid_out          = mid_res_r;
    mid_out.pixel[0] = rd_hit ? rd_bit : mid_res_r.pixel[0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (mid_adv) begin
      out_v_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_adv && mid_v_r) begin
      out_res_r <= mid_out;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.xlen, out_res_r.data, out_res_r.pixel};
  assign out_tuser  = {out_res_r.status, out_res_r.done, out_res_r.data_valid};

  // a refused embed never reports progress
  `LSBSE_ASSERT_IMPL(a_refused_quiet, out_v_r && out_res_r.status,
    !out_res_r.data_valid && !out_res_r.done, "refused item reports progress")

  // first_byte restarts the position so the next position is one
  `LSBSE_ASSERT_NEXT(a_first_restart, in_acc && is_img && first,
    bitpos_r == 12'd1, "position not restarted by first_byte")

  // a completed extracted byte clears the assembly register
  `LSBSE_ASSERT_NEXT(a_asm_clear, in_acc && is_img && res_nxt.data_valid,
    asm_r == 8'd0, "assembly byte not cleared after output")

endmodule
